// ----- src/tchp_pkg.sv -----
package tchp_pkg;

    localparam int unsigned RandomLen = 32;
    localparam logic [7:0] HostNameType = 8'h00;
    localparam logic [15:0] ExtSni = 16'd0;
    localparam logic [15:0] ExtGroups = 16'd10;
    localparam logic [15:0] ExtAlpn = 16'd16;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic [4:0] {
        PH_VER, PH_RAND, PH_SID_LEN, PH_SID, PH_CS_LEN, PH_CS, PH_CM_LEN, PH_CM,
        PH_EXT_LEN, PH_EXT_HDR, PH_SNI_LEN, PH_SNI_HDR, PH_SNI_NAME, PH_SNI_OTHER,
        PH_ALPN_LEN, PH_ALPN_PLEN, PH_ALPN_NAME, PH_GRP_LEN, PH_GRP, PH_BODY_SKIP,
        PH_REGION_SKIP, PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        EV_VERSION = 4'd0, EV_RANDOM = 4'd1, EV_SESSION = 4'd2, EV_CIPHER = 4'd3,
        EV_COMPRESSION = 4'd4, EV_EXT_HEADER = 4'd5, EV_SNI_START = 4'd6,
        EV_SNI_BYTE = 4'd7, EV_ALPN_START = 4'd8, EV_ALPN_BYTE = 4'd9,
        EV_GROUP = 4'd10, EV_DONE = 4'd11, EV_TRUNCATED = 4'd12
    } event_kind_t;

    localparam logic [1:0] CfgCipher = 2'd0;
    localparam logic [1:0] CfgCompression = 2'd1;
    localparam logic [1:0] CfgExtension = 2'd2;
    localparam logic [1:0] CfgGroup = 2'd3;

    typedef struct packed {
        event_kind_t kind;
        logic [15:0] value;
        logic [15:0] extra;
        logic [15:0] position;
        logic        last;
    } event_t;

    // up to two events per byte
    typedef struct packed {
        logic   first_valid;
        event_t first;
        logic   second_valid;
        event_t second;
    } event_pair_t;

endpackage

// ----- src/tls_client_hello_parser_unit.sv -----
// A byte's events are registered in the event queue before they are offered.
// One byte per cycle is taken while the queue has a free entry; a byte with two events is offered as two transfers.
// The byte parser advances its state on each accepted byte; a four-entry event queue decouples output.
// Reset (rst_n, asynchronous, active low) clears parse state, queue and sets all
// clamp registers to all ones.
module tls_client_hello_parser_unit #(
    parameter int unsigned QUEUE_DEPTH = tchp_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] event_value, [31:16] event_extra,
                                        // [47:32] byte_position
    output logic [3:0]  m_axis_tuser,   // event_kind
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tchp_pkg::*;

    event_pair_t pair;
    event_t      ev;
    logic        accept;
    logic        can_push;

    // Take a byte whenever the queue has a free entry.
    assign s_axis_tready = can_push;
    assign accept = s_axis_tvalid && can_push;
    assign cfg_ready = 1'b1;

    tchp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .data_byte (s_axis_tdata),
        .is_last   (s_axis_tlast),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_value (cfg_data),
        .pair      (pair)
    );

    // Bytes that produce no event are dropped before the queue.
    tchp_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && pair.first_valid),
        .pair      (pair),
        .can_push  (can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_event (ev)
    );

    assign m_axis_tdata = {ev.position, ev.extra, ev.value};
    assign m_axis_tuser = ev.kind;
    assign m_axis_tlast = ev.last;

endmodule

// ----- src/tchp_front.sv -----
module tchp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           data_byte,
    input  logic                 is_last,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_value,
    output tchp_pkg::event_pair_t pair
);
    import tchp_pkg::*;

    logic [15:0] cipher_unk_reg, ext_unk_reg, group_unk_reg;
    logic [7:0]  comp_unk_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] fc_reg, fc_next, flen_reg, flen_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] region_reg, region_next, body_reg, body_next;
    logic [15:0] list_reg, list_next, entry_reg, entry_next;
    logic        sni_reg, sni_next, alpn_reg, alpn_next, done_reg, done_next;

    event_pair_t pr;
    logic [15:0] w16, t16;
    logic        in_region, in_body;
    event_t      ev_a, ev_b;
    logic        va, vb;

    assign pair = pr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_unk_reg <= 16'hFFFF;
            comp_unk_reg   <= 8'hFF;
            ext_unk_reg    <= 16'hFFFF;
            group_unk_reg  <= 16'hFFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CfgCipher:      cipher_unk_reg <= cfg_value;
                CfgCompression: comp_unk_reg   <= cfg_value[7:0];
                CfgExtension:   ext_unk_reg    <= cfg_value;
                CfgGroup:       group_unk_reg  <= cfg_value;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_VER;
            fc_reg     <= '0;
            flen_reg   <= '0;
            held_reg   <= '0;
            region_reg <= '0;
            body_reg   <= '0;
            list_reg   <= '0;
            entry_reg  <= '0;
            sni_reg    <= 1'b0;
            alpn_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (in_valid)
        begin
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            flen_reg   <= flen_next;
            held_reg   <= held_next;
            region_reg <= region_next;
            body_reg   <= body_next;
            list_reg   <= list_next;
            entry_reg  <= entry_next;
            sni_reg    <= sni_next;
            alpn_reg   <= alpn_next;
            done_reg   <= done_next;
        end
    end

    function automatic event_t mk(event_kind_t k, logic [15:0] v, logic [15:0] x,
                                  logic [15:0] p);
        event_t e;
        e.kind = k;
        e.value = v;
        e.extra = x;
        e.position = p;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic logic [15:0] clamp(logic [15:0] v, logic [15:0] lim);
        return (v >= lim) ? lim : v;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        fc_next     = fc_reg;
        flen_next   = flen_reg;
        held_next   = held_reg;
        region_next = region_reg;
        body_next   = body_reg;
        list_next   = list_reg;
        entry_next  = entry_reg;
        sni_next    = sni_reg;
        alpn_next   = alpn_reg;
        done_next   = done_reg;
        va = 1'b0;
        vb = 1'b0;
        ev_a = mk(EV_DONE, '0, '0, '0);
        ev_b = mk(EV_DONE, '0, '0, '0);
        w16 = {held_reg, data_byte};
        t16 = '0;
        in_region = (phase_reg >= PH_EXT_HDR) && (phase_reg <= PH_REGION_SKIP);
        in_body = (phase_reg >= PH_SNI_LEN) && (phase_reg <= PH_BODY_SKIP);
        if (in_region)
            region_next = region_reg - 16'd1;
        if (in_body)
            body_next = body_reg - 16'd1;

        case (phase_reg)
            PH_VER:
            begin
                if (fc_reg == 16'd0)
                begin
                    held_next = data_byte;
                    fc_next = 16'd1;
                end
                else
                begin
                    va = 1'b1;
                    ev_a = mk(EV_VERSION, w16, '0, '0);
                    fc_next = '0;
                    phase_next = PH_RAND;
                end
            end
            PH_RAND:
            begin
                va = 1'b1;
                ev_a = mk(EV_RANDOM, {8'd0, data_byte}, '0, fc_reg);
                fc_next = fc_reg + 16'd1;
                if (fc_next >= 16'(RandomLen))
                begin
                    fc_next = '0;
                    phase_next = PH_SID_LEN;
                end
            end
            PH_SID_LEN:
            begin
                flen_next = {8'd0, data_byte};
                fc_next = '0;
                phase_next = (data_byte != 8'd0) ? PH_SID : PH_CS_LEN;
            end
            PH_SID:
            begin
                va = 1'b1;
                ev_a = mk(EV_SESSION, {8'd0, data_byte}, '0, fc_reg);
                fc_next = fc_reg + 16'd1;
                if (fc_next >= flen_reg)
                begin
                    fc_next = '0;
                    phase_next = PH_CS_LEN;
                end
            end
            PH_CS_LEN:
            begin
                if (fc_reg == 16'd0)
                begin
                    held_next = data_byte;
                    fc_next = 16'd1;
                end
                else
                begin
                    flen_next = w16;
                    fc_next = '0;
                    entry_next = '0;
                    phase_next = (w16 != 16'd0) ? PH_CS : PH_CM_LEN;
                end
            end
            PH_CS:
            begin
                if (fc_reg[0])
                begin
                    va = 1'b1;
                    ev_a = mk(EV_CIPHER, clamp(w16, cipher_unk_reg), entry_reg, entry_reg);
                    entry_next = entry_reg + 16'd1;
                end
                else
                    held_next = data_byte;
                fc_next = fc_reg + 16'd1;
                if (fc_next >= flen_reg)
                begin
                    fc_next = '0;
                    phase_next = PH_CM_LEN;
                end
            end
            PH_CM_LEN:
            begin
                flen_next = {8'd0, data_byte};
                fc_next = '0;
                entry_next = '0;
                phase_next = (data_byte != 8'd0) ? PH_CM : PH_EXT_LEN;
            end
            PH_CM:
            begin
                va = 1'b1;
                ev_a = mk(EV_COMPRESSION,
                          {8'd0, (data_byte >= comp_unk_reg) ? comp_unk_reg : data_byte},
                          fc_reg, fc_reg);
                fc_next = fc_reg + 16'd1;
                if (fc_next >= flen_reg)
                begin
                    fc_next = '0;
                    phase_next = PH_EXT_LEN;
                end
            end
            PH_EXT_LEN:
            begin
                if (fc_reg == 16'd0)
                begin
                    held_next = data_byte;
                    fc_next = 16'd1;
                end
                else
                begin
                    region_next = w16;
                    fc_next = '0;
                    if (w16 == 16'd0)
                    begin
                        va = 1'b1;
                        ev_a = mk(EV_DONE, '0, '0, '0);
                        phase_next = PH_DONE;
                        done_next = 1'b1;
                    end
                    else
                        phase_next = (w16 < 16'd4) ? PH_REGION_SKIP : PH_EXT_HDR;
                end
            end
            PH_EXT_HDR:
            begin
                if (fc_reg == 16'd0 || fc_reg == 16'd2)
                begin
                    held_next = data_byte;
                    fc_next = fc_reg + 16'd1;
                end
                else if (fc_reg == 16'd1)
                begin
                    flen_next = w16;
                    fc_next = 16'd2;
                end
                else
                begin
                    fc_next = '0;
                    if (w16 > region_next)
                        phase_next = PH_REGION_SKIP;
                    else
                    begin
                        body_next = w16;
                        t16 = clamp(flen_reg, ext_unk_reg);
                        va = 1'b1;
                        ev_a = mk(EV_EXT_HEADER, t16, w16, '0);
                        if (w16 == 16'd0)
                            phase_next = (region_next < 16'd4) ? PH_REGION_SKIP : PH_EXT_HDR;
                        else if (t16 == ExtSni && !sni_reg)
                        begin
                            sni_next = 1'b1;
                            phase_next = (w16 >= 16'd4) ? PH_SNI_LEN : PH_BODY_SKIP;
                        end
                        else if (t16 == ExtAlpn && !alpn_reg)
                        begin
                            alpn_next = 1'b1;
                            phase_next = (w16 >= 16'd2) ? PH_ALPN_LEN : PH_BODY_SKIP;
                        end
                        else if (t16 == ExtGroups)
                            phase_next = (w16 >= 16'd2) ? PH_GRP_LEN : PH_BODY_SKIP;
                        else
                            phase_next = PH_BODY_SKIP;
                    end
                end
            end
            PH_SNI_LEN, PH_ALPN_LEN, PH_GRP_LEN:
            begin
                if (fc_reg == 16'd0)
                begin
                    held_next = data_byte;
                    fc_next = 16'd1;
                end
                else
                begin
                    fc_next = '0;
                    entry_next = '0;
                    if (phase_reg == PH_GRP_LEN)
                    begin
                        t16 = (w16 > body_next) ? body_next : w16;
                        list_next = {t16[15:1], 1'b0};
                        phase_next = (list_next != 16'd0) ? PH_GRP : PH_BODY_SKIP;
                    end
                    else if (w16 > body_next)
                        phase_next = PH_BODY_SKIP;
                    else
                    begin
                        list_next = w16;
                        if (phase_reg == PH_SNI_LEN)
                            phase_next = (w16 < 16'd3) ? PH_BODY_SKIP : PH_SNI_HDR;
                        else
                            phase_next = (w16 == 16'd0) ? PH_BODY_SKIP : PH_ALPN_PLEN;
                    end
                end
            end
            PH_SNI_HDR:
            begin
                list_next = list_reg - 16'd1;
                if (fc_reg == 16'd0)
                begin
                    flen_next = {8'd0, data_byte};
                    fc_next = 16'd1;
                end
                else if (fc_reg == 16'd1)
                begin
                    held_next = data_byte;
                    fc_next = 16'd2;
                end
                else
                begin
                    fc_next = '0;
                    if (w16 > list_next)
                        phase_next = PH_BODY_SKIP;
                    else
                    begin
                        flen_next = w16;
                        if (flen_reg[7:0] == HostNameType)
                        begin
                            va = 1'b1;
                            ev_a = mk(EV_SNI_START, w16, entry_reg, '0);
                            if (w16 == 16'd0)
                            begin
                                entry_next = entry_reg + 16'd1;
                                phase_next = (list_next < 16'd3) ? PH_BODY_SKIP : PH_SNI_HDR;
                            end
                            else
                                phase_next = PH_SNI_NAME;
                        end
                        else if (w16 == 16'd0)
                            phase_next = (list_next < 16'd3) ? PH_BODY_SKIP : PH_SNI_HDR;
                        else
                            phase_next = PH_SNI_OTHER;
                    end
                end
            end
            PH_SNI_NAME, PH_SNI_OTHER:
            begin
                list_next = list_reg - 16'd1;
                if (phase_reg == PH_SNI_NAME)
                begin
                    va = 1'b1;
                    ev_a = mk(EV_SNI_BYTE, {8'd0, data_byte}, entry_reg, fc_reg);
                end
                fc_next = fc_reg + 16'd1;
                if (fc_next >= flen_reg)
                begin
                    if (phase_reg == PH_SNI_NAME)
                        entry_next = entry_reg + 16'd1;
                    fc_next = '0;
                    phase_next = (list_next < 16'd3) ? PH_BODY_SKIP : PH_SNI_HDR;
                end
            end
            PH_ALPN_PLEN:
            begin
                list_next = list_reg - 16'd1;
                if ({8'd0, data_byte} > list_next)
                    phase_next = PH_BODY_SKIP;
                else
                begin
                    va = 1'b1;
                    ev_a = mk(EV_ALPN_START, {8'd0, data_byte}, entry_reg, '0);
                    if (data_byte == 8'd0)
                    begin
                        entry_next = entry_reg + 16'd1;
                        fc_next = '0;
                        phase_next = (list_next == 16'd0) ? PH_BODY_SKIP : PH_ALPN_PLEN;
                    end
                    else
                    begin
                        flen_next = {8'd0, data_byte};
                        fc_next = '0;
                        phase_next = PH_ALPN_NAME;
                    end
                end
            end
            PH_ALPN_NAME:
            begin
                list_next = list_reg - 16'd1;
                va = 1'b1;
                ev_a = mk(EV_ALPN_BYTE, {8'd0, data_byte}, entry_reg, fc_reg);
                fc_next = fc_reg + 16'd1;
                if (fc_next >= flen_reg)
                begin
                    entry_next = entry_reg + 16'd1;
                    fc_next = '0;
                    phase_next = (list_next == 16'd0) ? PH_BODY_SKIP : PH_ALPN_PLEN;
                end
            end
            PH_GRP:
            begin
                list_next = list_reg - 16'd1;
                if (fc_reg == 16'd0)
                begin
                    held_next = data_byte;
                    fc_next = 16'd1;
                end
                else
                begin
                    va = 1'b1;
                    ev_a = mk(EV_GROUP, clamp(w16, group_unk_reg), entry_reg, entry_reg);
                    entry_next = entry_reg + 16'd1;
                    fc_next = '0;
                    if (list_next == 16'd0)
                        phase_next = PH_BODY_SKIP;
                end
            end
            default:
            begin
            end
        endcase

        // end of extension body, then end of region
        if (in_body && body_next == 16'd0)
        begin
            fc_next = '0;
            phase_next = (region_next < 16'd4) ? PH_REGION_SKIP : PH_EXT_HDR;
        end
        if (in_region && region_next == 16'd0)
        begin
            if (va)
            begin
                vb = 1'b1;
                ev_b = mk(EV_DONE, '0, '0, '0);
            end
            else
            begin
                va = 1'b1;
                ev_a = mk(EV_DONE, '0, '0, '0);
            end
            phase_next = PH_DONE;
            done_next = 1'b1;
        end
        if (is_last)
        begin
            if (!done_next)
            begin
                if (va)
                begin
                    vb = 1'b1;
                    ev_b = mk(EV_TRUNCATED, '0, '0, '0);
                end
                else
                begin
                    va = 1'b1;
                    ev_a = mk(EV_TRUNCATED, '0, '0, '0);
                end
            end
            phase_next  = PH_VER;
            fc_next     = '0;
            flen_next   = '0;
            held_next   = '0;
            region_next = '0;
            body_next   = '0;
            list_next   = '0;
            entry_next  = '0;
            sni_next    = 1'b0;
            alpn_next   = 1'b0;
            done_next   = 1'b0;
        end
        if (vb)
            ev_b.last = 1'b1;
        else
            ev_a.last = 1'b1;
        pr.first_valid  = va;
        pr.first        = ev_a;
        pr.second_valid = vb;
        pr.second       = ev_b;
    end

endmodule

// ----- src/tchp_back.sv -----
module tchp_back #(
    parameter int unsigned DEPTH = tchp_pkg::QueueDepth
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tchp_pkg::event_pair_t pair,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tchp_pkg::event_t     out_event
);
    import tchp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    event_pair_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   count_reg;
    logic          half_reg;
    event_pair_t   head;
    logic          pop_entry, fire;

    assign head      = mem[rd_reg];
    assign out_valid = (count_reg != '0);
    assign out_event = half_reg ? head.second : head.first;
    assign fire      = out_valid && out_ready;
    assign pop_entry = fire && (half_reg || !head.second_valid);
    assign can_push  = (count_reg != (AW+1)'(DEPTH)) || pop_entry;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            if (pop_entry)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            if (fire)
                half_reg <= !pop_entry;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop_entry);
        end
    end

endmodule

// ----- tb/tchp_checker.sv -----
module tchp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          pending,
    output int          errors
);
    import tchp_pkg::*;

    logic [15:0] lim_cipher, lim_ext, lim_group;
    logic [7:0]  lim_comp;

    phase_t      phase;
    logic [15:0] fcount, flen, region_left, body_left, list_left, entry;
    logic [7:0]  held;
    logic        sni_seen, alpn_seen, complete;

    event_t      expected_events[$];

    function automatic event_t mk(event_kind_t k, logic [15:0] v, logic [15:0] x,
                                  logic [15:0] p);
        event_t e;
        e.kind = k;
        e.value = v;
        e.extra = x;
        e.position = p;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic logic [15:0] clamp(logic [15:0] v, logic [15:0] lim);
        return (v >= lim) ? lim : v;
    endfunction

    function void clear_message();
        phase = PH_VER;
        fcount = '0;
        flen = '0;
        held = '0;
        region_left = '0;
        body_left = '0;
        list_left = '0;
        entry = '0;
        sni_seen = 1'b0;
        alpn_seen = 1'b0;
        complete = 1'b0;
    endfunction

    function void next_ext();
        fcount = '0;
        phase = (region_left < 16'd4) ? PH_REGION_SKIP : PH_EXT_HDR;
    endfunction

    function void next_sni();
        fcount = '0;
        phase = (list_left < 16'd3) ? PH_BODY_SKIP : PH_SNI_HDR;
    endfunction

    function void next_alpn();
        fcount = '0;
        phase = (list_left == 16'd0) ? PH_BODY_SKIP : PH_ALPN_PLEN;
    endfunction

    // advance the parse by one byte and queue the events it causes
    function automatic void parse_byte(logic [7:0] b, logic lst);
        event_t      evs[$];
        logic [15:0] w, t;
        phase_t      ph;
        logic        in_region, in_body;
        ph = phase;
        in_region = (ph >= PH_EXT_HDR) && (ph <= PH_REGION_SKIP);
        in_body = (ph >= PH_SNI_LEN) && (ph <= PH_BODY_SKIP);
        if (in_region) region_left--;
        if (in_body) body_left--;
        case (ph)
            PH_VER:
                if (fcount == 0)
                begin
                    held = b;
                    fcount = 1;
                end
                else
                begin
                    evs = {evs, mk(EV_VERSION, {held, b}, '0, '0)};
                    fcount = 0;
                    phase = PH_RAND;
                end
            PH_RAND:
            begin
                evs = {evs, mk(EV_RANDOM, {8'h00, b}, '0, fcount)};
                fcount++;
                if (fcount >= RandomLen)
                begin
                    fcount = 0;
                    phase = PH_SID_LEN;
                end
            end
            PH_SID_LEN:
            begin
                flen = {8'h00, b};
                fcount = 0;
                phase = (b != 0) ? PH_SID : PH_CS_LEN;
            end
            PH_SID:
            begin
                evs = {evs, mk(EV_SESSION, {8'h00, b}, '0, fcount)};
                fcount++;
                if (fcount >= flen)
                begin
                    fcount = 0;
                    phase = PH_CS_LEN;
                end
            end
            PH_CS_LEN:
                if (fcount == 0)
                begin
                    held = b;
                    fcount = 1;
                end
                else
                begin
                    flen = {held, b};
                    fcount = 0;
                    entry = 0;
                    phase = (flen != 0) ? PH_CS : PH_CM_LEN;
                end
            PH_CS:
            begin
                if (fcount[0])
                begin
                    evs = {evs, mk(EV_CIPHER, clamp({held, b}, lim_cipher), entry, entry)};
                    entry++;
                end
                else
                    held = b;
                fcount++;
                if (fcount >= flen)
                begin
                    fcount = 0;
                    phase = PH_CM_LEN;
                end
            end
            PH_CM_LEN:
            begin
                flen = {8'h00, b};
                fcount = 0;
                entry = 0;
                phase = (b != 0) ? PH_CM : PH_EXT_LEN;
            end
            PH_CM:
            begin
                evs = {evs, mk(EV_COMPRESSION,
                               {8'h00, (b >= lim_comp) ? lim_comp : b}, fcount, fcount)};
                fcount++;
                if (fcount >= flen)
                begin
                    fcount = 0;
                    phase = PH_EXT_LEN;
                end
            end
            PH_EXT_LEN:
                if (fcount == 0)
                begin
                    held = b;
                    fcount = 1;
                end
                else
                begin
                    region_left = {held, b};
                    fcount = 0;
                    if (region_left == 0)
                    begin
                        evs = {evs, mk(EV_DONE, '0, '0, '0)};
                        phase = PH_DONE;
                        complete = 1'b1;
                    end
                    else
                        next_ext();
                end
            PH_EXT_HDR:
                if (fcount == 0 || fcount == 2)
                begin
                    held = b;
                    fcount++;
                end
                else if (fcount == 1)
                begin
                    flen = {held, b};
                    fcount = 2;
                end
                else
                begin
                    w = {held, b};
                    fcount = 0;
                    if (w > region_left)
                        phase = PH_REGION_SKIP;
                    else
                    begin
                        body_left = w;
                        t = clamp(flen, lim_ext);
                        evs = {evs, mk(EV_EXT_HEADER, t, w, '0)};
                        if (w == 0)
                            next_ext();
                        else if (t == ExtSni && !sni_seen)
                        begin
                            sni_seen = 1'b1;
                            phase = (w >= 4) ? PH_SNI_LEN : PH_BODY_SKIP;
                        end
                        else if (t == ExtAlpn && !alpn_seen)
                        begin
                            alpn_seen = 1'b1;
                            phase = (w >= 2) ? PH_ALPN_LEN : PH_BODY_SKIP;
                        end
                        else if (t == ExtGroups)
                            phase = (w >= 2) ? PH_GRP_LEN : PH_BODY_SKIP;
                        else
                            phase = PH_BODY_SKIP;
                    end
                end
            PH_SNI_LEN, PH_ALPN_LEN, PH_GRP_LEN:
                if (fcount == 0)
                begin
                    held = b;
                    fcount = 1;
                end
                else
                begin
                    w = {held, b};
                    fcount = 0;
                    entry = 0;
                    if (ph == PH_GRP_LEN)
                    begin
                        if (w > body_left) w = body_left;
                        list_left = w & 16'hFFFE;
                        phase = (list_left != 0) ? PH_GRP : PH_BODY_SKIP;
                    end
                    else if (w > body_left)
                        phase = PH_BODY_SKIP;
                    else
                    begin
                        list_left = w;
                        if (ph == PH_SNI_LEN) next_sni();
                        else next_alpn();
                    end
                end
            PH_SNI_HDR:
            begin
                list_left--;
                if (fcount == 0)
                begin
                    flen = {8'h00, b};
                    fcount = 1;
                end
                else if (fcount == 1)
                begin
                    held = b;
                    fcount = 2;
                end
                else
                begin
                    w = {held, b};
                    t = flen;
                    fcount = 0;
                    if (w > list_left)
                        phase = PH_BODY_SKIP;
                    else
                    begin
                        flen = w;
                        if (t[7:0] == HostNameType && t[15:8] == 0)
                        begin
                            evs = {evs, mk(EV_SNI_START, w, entry, '0)};
                            if (w == 0)
                            begin
                                entry++;
                                next_sni();
                            end
                            else
                                phase = PH_SNI_NAME;
                        end
                        else if (w == 0)
                            next_sni();
                        else
                            phase = PH_SNI_OTHER;
                    end
                end
            end
            PH_SNI_NAME:
            begin
                list_left--;
                evs = {evs, mk(EV_SNI_BYTE, {8'h00, b}, entry, fcount)};
                fcount++;
                if (fcount >= flen)
                begin
                    entry++;
                    next_sni();
                end
            end
            PH_SNI_OTHER:
            begin
                list_left--;
                fcount++;
                if (fcount >= flen) next_sni();
            end
            PH_ALPN_PLEN:
            begin
                list_left--;
                if ({8'h00, b} > list_left)
                    phase = PH_BODY_SKIP;
                else
                begin
                    evs = {evs, mk(EV_ALPN_START, {8'h00, b}, entry, '0)};
                    if (b == 0)
                    begin
                        entry++;
                        next_alpn();
                    end
                    else
                    begin
                        flen = {8'h00, b};
                        fcount = 0;
                        phase = PH_ALPN_NAME;
                    end
                end
            end
            PH_ALPN_NAME:
            begin
                list_left--;
                evs = {evs, mk(EV_ALPN_BYTE, {8'h00, b}, entry, fcount)};
                fcount++;
                if (fcount >= flen)
                begin
                    entry++;
                    next_alpn();
                end
            end
            PH_GRP:
            begin
                list_left--;
                if (fcount == 0)
                begin
                    held = b;
                    fcount = 1;
                end
                else
                begin
                    evs = {evs, mk(EV_GROUP, clamp({held, b}, lim_group), entry, entry)};
                    entry++;
                    fcount = 0;
                    if (list_left == 0) phase = PH_BODY_SKIP;
                end
            end
            default: ;
        endcase
        if (in_body && body_left == 0) next_ext();
        if (in_region && region_left == 0)
        begin
            evs = {evs, mk(EV_DONE, '0, '0, '0)};
            phase = PH_DONE;
            complete = 1'b1;
        end
        if (lst)
        begin
            if (!complete) evs = {evs, mk(EV_TRUNCATED, '0, '0, '0)};
            clear_message();
        end
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i]) expected_events = {expected_events, evs[i]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        event_t want;
        if (!rst_n)
        begin
            lim_cipher = 16'hFFFF;
            lim_comp = 8'hFF;
            lim_ext = 16'hFFFF;
            lim_group = 16'hFFFF;
            clear_message();
            expected_events.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CfgCipher:      lim_cipher = cfg_data;
                    CfgCompression: lim_comp = cfg_data[7:0];
                    CfgExtension:   lim_ext = cfg_data;
                    CfgGroup:       lim_group = cfg_data;
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event: kind %0d value %h", m_axis_tuser,
                           m_axis_tdata[15:0]);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_axis_tuser != want.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[15:0] != want.value)
                    begin
                        $error("event_value: expected %h, got %h", want.value,
                               m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[31:16] != want.extra)
                    begin
                        $error("event_extra: expected %h, got %h", want.extra,
                               m_axis_tdata[31:16]);
                        errors++;
                    end
                    if (m_axis_tdata[47:32] != want.position)
                    begin
                        $error("byte_position: expected %h, got %h", want.position,
                               m_axis_tdata[47:32]);
                        errors++;
                    end
                    if (m_axis_tlast != want.last)
                    begin
                        $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            pending = expected_events.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import tchp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [15:0] event_value, [31:16] event_extra, [47:32] position
    logic [3:0]  m_axis_tuser;   // event_kind
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          pending;
    int          errors;

    // quiet: no idling on either side, used for the last part of the run
    logic        quiet;
    int          bytes_sent;
    logic [7:0]  msg[$];

    tls_client_hello_parser_unit dut (.*);

    tchp_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver side: random stall bursts unless quiet
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // hold one byte until its transfer; maybe drop valid for a burst afterward
    task automatic send_byte(logic [7:0] b, logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 11) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    // raise valid and hold it until the transfer; the caller drops it
    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_limits(logic [15:0] cs, logic [7:0] cm, logic [15:0] ext,
                              logic [15:0] grp);
        write_cfg(CfgCipher, cs);
        write_cfg(CfgCompression, {8'h00, cm});
        write_cfg(CfgExtension, ext);
        write_cfg(CfgGroup, grp);
        cfg_valid <= 1'b0;
    endtask

    function automatic void put16(int v);
        msg = {msg, v[15:8]};
        msg = {msg, v[7:0]};
    endfunction

    // append one extension (header plus body) to ext, mostly well formed
    function automatic void build_ext(ref logic [7:0] ext[$]);
        logic [7:0] body[$];
        logic [7:0] lst[$];
        int         kind, n, len, typ, blen, llen;
        kind = $urandom_range(0, 5);
        case (kind)
            0, 1:
            begin
                typ = (kind == 0) ? ExtSni : ExtAlpn;
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    len = $urandom_range(0, 6);
                    if (kind == 0)
                    begin
                        lst = {lst, 8'(($urandom_range(0, 4) == 0) ?
                                       $urandom_range(1, 255) : 0)};
                        lst = {lst, 8'h00};
                    end
                    lst = {lst, 8'(len)};
                    for (int j = 0; j < len; j++) lst = {lst, 8'($urandom)};
                end
                // broken list or name length now and then
                if (lst.size() > 0 && $urandom_range(0, 7) == 0)
                    lst[$urandom_range(0, lst.size() - 1)] = 8'($urandom);
                llen = lst.size();
                if ($urandom_range(0, 9) == 0) llen = llen + $urandom_range(1, 4);
                body = {body, llen[15:8]};
                body = {body, llen[7:0]};
                foreach (lst[i]) body = {body, lst[i]};
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(0, 2)) void'(body.pop_back());
            end
            2:
            begin
                typ = ExtGroups;
                n = $urandom_range(0, 4);
                llen = 2 * n;
                if ($urandom_range(0, 5) == 0) llen = $urandom_range(0, 12);
                body = {body, llen[15:8]};
                body = {body, llen[7:0]};
                repeat (2 * n) body = {body, 8'($urandom)};
                if ($urandom_range(0, 7) == 0) body = {body, 8'($urandom)};
            end
            3:
            begin
                typ = $urandom_range(0, 40);
                repeat ($urandom_range(0, 5)) body = {body, 8'($urandom)};
            end
            default:
            begin
                typ = $urandom_range(0, 65535);
                repeat ($urandom_range(0, 4)) body = {body, 8'($urandom)};
            end
        endcase
        blen = body.size();
        if ($urandom_range(0, 15) == 0) blen = blen + $urandom_range(1, 8);
        ext = {ext, typ[15:8]};
        ext = {ext, typ[7:0]};
        ext = {ext, blen[15:8]};
        ext = {ext, blen[7:0]};
        foreach (body[i]) ext = {ext, body[i]};
    endfunction

    // build one message into msg and send it; some are cut short, some are noise
    task automatic send_hello();
        logic [7:0] ext[$];
        int         n, rlen, cut;
        msg.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 40)) msg = {msg, 8'($urandom)};
        else
        begin
            put16($urandom_range(0, 65535));
            repeat (RandomLen) msg = {msg, 8'($urandom)};
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32);
            msg = {msg, 8'(n)};
            repeat (n) msg = {msg, 8'($urandom)};
            n = $urandom_range(0, 12);
            put16(n);
            repeat (n) msg = {msg, 8'($urandom)};
            n = $urandom_range(0, 4);
            msg = {msg, 8'(n)};
            repeat (n) msg = {msg, 8'($urandom)};
            repeat ($urandom_range(0, 5)) build_ext(ext);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) ext = {ext, 8'($urandom)};
            rlen = ext.size();
            if ($urandom_range(0, 11) == 0) rlen = rlen + $urandom_range(1, 20);
            put16(rlen);
            foreach (ext[i]) msg = {msg, ext[i]};
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) msg = {msg, 8'($urandom)};
        end
        cut = msg.size();
        if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, msg.size());
        for (int i = 0; i < cut; i++) send_byte(msg[i], i == cut - 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        bytes_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone bytes that end the buffer, a version then truncation,
        // and the shortest complete message with an empty extension region
        // followed by one trailing byte
        set_limits(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h03, 1'b1);
        msg.delete();
        put16(16'h0303);
        repeat (RandomLen) msg = {msg, 8'hA5};
        repeat (6) msg = {msg, 8'h00};
        msg = {msg, 8'h5A};
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: ;
                1: set_limits(16'h0000, 8'h00, 16'h0000, 16'h0000);
                2: set_limits(16'($urandom), 8'($urandom_range(0, 3)),
                              16'($urandom_range(8, 40)), 16'($urandom));
                default:
                begin
                    set_limits(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
                    quiet = 1'b1;
                end
            endcase
            bytes_sent = 0;
            while (bytes_sent < 270)
            begin
                send_hello();
                // in phase 2, let the output side empty after each message once more than 150 bytes are sent
                if (ph == 2 && bytes_sent > 150 && bytes_sent < 300)
                begin
                    s_axis_tvalid <= 1'b0;
                    do @(negedge clk); while (pending != 0);
                    @(posedge clk);
                end
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tchp_pkg.sv
src/tchp_front.sv
src/tchp_back.sv
src/tls_client_hello_parser_unit.sv
tb/tchp_checker.sv
tb/testbench.sv
